[design/assert_macros.svh]
// Assertion macros shared by the balance controller RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a reset that disables the check
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen on a clock edge
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   `ASSERT_CLK(label, clk, rst, !(expr), msg)

`endif

[design/brc_pkg.sv]
// Types, gains and helper functions of the balance cascade controller.
// Depends on nothing; the other design files but the assertion macros refer to it by scoped names.
package brc_pkg;

   // Payload and datapath widths
   localparam int WideW = 52;

   typedef logic signed [16:0] angle_type;
   typedef logic signed [15:0] word_type;
   typedef logic signed [31:0] dword_type;
   typedef logic        [31:0] ms_type;
   typedef logic signed [32:0] speed_type;
   typedef logic signed [33:0] mul_a_type;
   typedef logic signed [17:0] mul_b_type;
   typedef logic signed [WideW-1:0] wide_type;
   typedef logic signed [10:0] pos_type;
   typedef logic        [1:0]  csr_index_type;
   typedef logic        [15:0] csr_data_type;

   // Register indexes
   localparam csr_index_type CsrMaxTilt     = 2'd0;
   localparam csr_index_type CsrRestand     = 2'd1;
   localparam csr_index_type CsrSpeedScale  = 2'd2;

   // Register reset values
   localparam logic [7:0]   MaxTiltReset    = 8'd40;
   localparam csr_data_type RestandReset    = 16'd1000;
   localparam csr_data_type SpeedScaleReset = 16'd256;

   // Q8.8 gains
   localparam mul_b_type KpBal       = 18'sd115;
   localparam mul_b_type KdBal       = 18'sd54;
   localparam mul_b_type KSmoothKeep = 18'sd179;
   localparam mul_b_type KSmoothNew  = 18'sd77;
   localparam mul_b_type KVelKeep    = 18'sd205;
   localparam mul_b_type KVelNew     = 18'sd51;
   localparam mul_b_type KpVel       = 18'sd358;
   localparam mul_b_type KpPos       = 18'sd77;

   // Position integrator limits
   localparam logic signed [16:0] PosMin = -17'sd1000;
   localparam logic signed [16:0] PosMax = 17'sd1000;

   // Datapath operations, one per controller step
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_STANDUP,
      OP_CLEAR,
      OP_SPEED,
      OP_BAL_A,
      OP_BAL_B,
      OP_ERR,
      OP_SE_A,
      OP_SE_B,
      OP_SM,
      OP_DIFF,
      OP_VE_A,
      OP_VE_B,
      OP_VEL_A,
      OP_VEL_B,
      OP_DRIVE
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic over_tilt;
      logic restand_wait;
   } sts_type;

   // Arithmetic shift right by k with rounding toward zero
   function automatic wide_type shr_trunc(input wide_type x, input int unsigned k);
      wide_type bias;
      bias = x[WideW-1] ? ((wide_type'(1) <<< k) - wide_type'(1)) : '0;
      return (x + bias) >>> k;
   endfunction

   // Saturate to a signed 16-bit value
   function automatic word_type sat16(input wide_type x);
      word_type r;
      if (x > wide_type'(32767)) begin
         r = 16'sh7FFF;
      end else if (x < -wide_type'(32768)) begin
         r = -16'sh8000;
      end else begin
         r = x[15:0];
      end
      return r;
   endfunction

   // Saturate to a signed 32-bit value
   function automatic dword_type sat32(input wide_type x);
      dword_type r;
      if (x > wide_type'(32'sh7FFF_FFFF)) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -(wide_type'(1) <<< 31)) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

[design/brc_req_if.sv]
// Request channel of the balance controller: one IMU sample per request.
// Depends on brc_pkg for the field types.
interface brc_req_if;
   logic                valid;
   logic                ready;
   brc_pkg::angle_type  tilt_angle;
   brc_pkg::word_type   gyro_rate;
   brc_pkg::word_type   encoder_delta;
   brc_pkg::ms_type     now_ms;
   brc_pkg::word_type   target_speed;
   brc_pkg::word_type   target_turn;

   modport source (
      output valid, tilt_angle, gyro_rate, encoder_delta, now_ms, target_speed, target_turn,
      input  ready
   );
   modport sink (
      input  valid, tilt_angle, gyro_rate, encoder_delta, now_ms, target_speed, target_turn,
      output ready
   );
endinterface

[design/brc_rsp_if.sv]
// Response channel of the balance controller: drive or shutdown command.
// Depends on brc_pkg for the field types.
interface brc_rsp_if;
   logic              valid;
   logic              ready;
   logic              kind;
   brc_pkg::word_type drive;
   brc_pkg::word_type turn;

   modport source (output valid, kind, drive, turn, input ready);
   modport sink   (input  valid, kind, drive, turn, output ready);
endinterface

[design/balance_robot_cascade_controller_core.sv]
// Balance cascade controller core. A dropped (odd) request gives no response.
// A shutdown response is raised from the check and shut states once the output is free;
// a drive response after the steps from speed to drive through the one shared 34x18 multiplier.
// A kept request holds the block busy until it is back in idle; it takes no new request before.
// Reset is synchronous: it clears control and loop state and loads register defaults.
`include "assert_macros.svh"

module balance_robot_cascade_controller_core (
   input  logic                   clock,
   input  logic                   reset,
   brc_req_if.sink                req_ch,
   brc_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  brc_pkg::csr_index_type csr_index,
   input  brc_pkg::csr_data_type  csr_wdata
);

   brc_pkg::cmd_type cmd;
   brc_pkg::sts_type sts;

   // Handshake and payload terms for the checks
   logic req_fire;
   logic shut_nonzero;

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign shut_nonzero = rsp_ch.valid && rsp_ch.kind
                         && (rsp_ch.drive != 16'sd0 || rsp_ch.turn != 16'sd0);

   brc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   brc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .tilt_angle    (req_ch.tilt_angle),
      .gyro_rate     (req_ch.gyro_rate),
      .encoder_delta (req_ch.encoder_delta),
      .now_ms        (req_ch.now_ms),
      .target_speed  (req_ch.target_speed),
      .target_turn   (req_ch.target_turn),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_kind      (rsp_ch.kind),
      .rsp_drive     (rsp_ch.drive),
      .rsp_turn      (rsp_ch.turn)
   );

   // A shutdown response carries no drive and no turn
   `ASSERT_NEVER(a_shutdown_zero, clock, reset, shut_nonzero, "shutdown with nonzero payload")

   // No response appears in the cycle right after a request is taken
   `ASSERT_CLK(a_min_latency, clock, reset, req_fire |=> !$rose(rsp_ch.valid), "early response")

endmodule

[design/brc_mul.sv]
// Shared signed multiplier with a registered product for the controller datapath.
// Depends on brc_pkg for operand and product types.
module brc_mul (
   input  logic               clock,
   input  brc_pkg::mul_a_type mul_a,
   input  brc_pkg::mul_b_type mul_b,
   output brc_pkg::wide_type  prod
);

   brc_pkg::wide_type prod_ff;
   brc_pkg::wide_type prod_in;

   // Form the full-width product
   always_comb begin
      prod_in = mul_a * mul_b;
   end

   // Register the product for the next step
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

[design/brc_datapath.sv]
// Datapath of the balance controller: sample and config registers, loop state,
// the step-by-step cascade arithmetic and the response payload. Uses brc_pkg, brc_mul.
module brc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  brc_pkg::cmd_type       cmd,
   output brc_pkg::sts_type       sts,
   input  brc_pkg::angle_type     tilt_angle,
   input  brc_pkg::word_type      gyro_rate,
   input  brc_pkg::word_type      encoder_delta,
   input  brc_pkg::ms_type        now_ms,
   input  brc_pkg::word_type      target_speed,
   input  brc_pkg::word_type      target_turn,
   input  logic                   csr_we,
   input  brc_pkg::csr_index_type csr_index,
   input  brc_pkg::csr_data_type  csr_wdata,
   output logic                   rsp_kind,
   output brc_pkg::word_type      rsp_drive,
   output brc_pkg::word_type      rsp_turn
);

   // Latched request fields
   brc_pkg::angle_type angle_ff, angle_in;
   brc_pkg::word_type  gyro_ff, gyro_in;
   brc_pkg::word_type  enc_ff, enc_in;
   brc_pkg::ms_type    now_ff, now_in;
   brc_pkg::word_type  tgt_ff, tgt_in;
   brc_pkg::word_type  turn_ff, turn_in;

   // Configuration registers
   logic [7:0]            max_tilt_ff, max_tilt_in;
   brc_pkg::csr_data_type delay_ff, delay_in;
   brc_pkg::csr_data_type scale_ff, scale_in;

   // Loop state
   brc_pkg::ms_type    standup_ff, standup_in;
   brc_pkg::pos_type   pos_sum_ff, pos_sum_in;
   brc_pkg::word_type  se_ff, se_in;
   brc_pkg::dword_type ve_ff, ve_in;

   // Intermediate terms
   brc_pkg::speed_type s_ff, s_in;
   brc_pkg::wide_type  t_ff, t_in;
   brc_pkg::word_type  bal_ff, bal_in;
   brc_pkg::word_type  err_ff, err_in;
   brc_pkg::word_type  sm_ff, sm_in;
   brc_pkg::word_type  pos_ff, pos_in;
   brc_pkg::word_type  vel_ff, vel_in;
   brc_pkg::mul_a_type diff_ff, diff_in;

   // Response payload
   logic              kind_ff, kind_in;
   brc_pkg::word_type drive_ff, drive_in;
   brc_pkg::word_type turn_out_ff, turn_out_in;

   // Multiplier operands and product
   brc_pkg::mul_a_type mul_a;
   brc_pkg::mul_b_type mul_b;
   brc_pkg::wide_type  prod;

   logic signed [16:0] pos_next;
   logic        [16:0] tilt_mag;

   brc_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // Flag a fall and a pending restand delay
   always_comb begin
      tilt_mag = angle_ff[16] ? 17'(-angle_ff) : 17'(angle_ff);
      sts.over_tilt    = tilt_mag[16:8] > {1'b0, max_tilt_ff};
      sts.restand_wait = (now_ff - 32'(delay_ff)) < standup_ff;
   end

   // Decode configuration writes
   always_comb begin
      max_tilt_in = max_tilt_ff;
      delay_in    = delay_ff;
      scale_in    = scale_ff;
      if (csr_we) begin
         case (csr_index)
            brc_pkg::CsrMaxTilt:    max_tilt_in = csr_wdata[7:0];
            brc_pkg::CsrRestand:    delay_in    = csr_wdata;
            brc_pkg::CsrSpeedScale: scale_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   // Run one step of the cascade per command
   always_comb begin
      angle_in    = angle_ff;
      gyro_in     = gyro_ff;
      enc_in      = enc_ff;
      now_in      = now_ff;
      tgt_in      = tgt_ff;
      turn_in     = turn_ff;
      standup_in  = standup_ff;
      pos_sum_in  = pos_sum_ff;
      se_in       = se_ff;
      ve_in       = ve_ff;
      s_in        = s_ff;
      t_in        = t_ff;
      bal_in      = bal_ff;
      err_in      = err_ff;
      sm_in       = sm_ff;
      pos_in      = pos_ff;
      vel_in      = vel_ff;
      diff_in     = diff_ff;
      kind_in     = kind_ff;
      drive_in    = drive_ff;
      turn_out_in = turn_out_ff;
      mul_a       = '0;
      mul_b       = '0;
      pos_next    = 17'(pos_sum_ff) + 17'(enc_ff);

      case (cmd.op)
         brc_pkg::OP_LOAD: begin
            angle_in = tilt_angle;
            gyro_in  = gyro_rate;
            enc_in   = encoder_delta;
            now_in   = now_ms;
            tgt_in   = target_speed;
            turn_in  = target_turn;
         end
         brc_pkg::OP_STANDUP: begin
            standup_in = now_ff;
         end
         brc_pkg::OP_CLEAR: begin
            pos_sum_in  = '0;
            se_in       = '0;
            ve_in       = '0;
            kind_in     = 1'b1;
            drive_in    = '0;
            turn_out_in = '0;
         end
         brc_pkg::OP_SPEED: begin
            // Speed product, and advance the clamped position integrator
            mul_a = brc_pkg::mul_a_type'(enc_ff);
            mul_b = $signed({2'b00, scale_ff});
            if (pos_next > brc_pkg::PosMax) begin
               pos_sum_in = 11'(brc_pkg::PosMax);
            end else if (pos_next < brc_pkg::PosMin) begin
               pos_sum_in = 11'(brc_pkg::PosMin);
            end else begin
               pos_sum_in = 11'(pos_next);
            end
         end
         brc_pkg::OP_BAL_A: begin
            s_in  = prod[32:0];
            mul_a = brc_pkg::mul_a_type'(angle_ff);
            mul_b = brc_pkg::KpBal;
         end
         brc_pkg::OP_BAL_B: begin
            t_in  = prod;
            mul_a = brc_pkg::mul_a_type'(gyro_ff);
            mul_b = brc_pkg::KdBal;
         end
         brc_pkg::OP_ERR: begin
            bal_in = brc_pkg::sat16(brc_pkg::shr_trunc(t_ff + prod, 8));
            err_in = brc_pkg::sat16(brc_pkg::shr_trunc(
                        (brc_pkg::wide_type'(tgt_ff) <<< 8) - brc_pkg::wide_type'(s_ff), 8));
            mul_a  = brc_pkg::mul_a_type'(se_ff);
            mul_b  = brc_pkg::KSmoothKeep;
         end
         brc_pkg::OP_SE_A: begin
            se_in = brc_pkg::sat16(brc_pkg::shr_trunc(prod, 8));
            mul_a = brc_pkg::mul_a_type'(err_ff);
            mul_b = brc_pkg::KSmoothNew;
         end
         brc_pkg::OP_SE_B: begin
            se_in = brc_pkg::sat16(brc_pkg::shr_trunc(
                       (brc_pkg::wide_type'(se_ff) <<< 8) + prod, 8));
            mul_a = brc_pkg::mul_a_type'(ve_ff);
            mul_b = brc_pkg::KVelKeep;
         end
         brc_pkg::OP_SM: begin
            sm_in = brc_pkg::sat16(brc_pkg::shr_trunc(
                       brc_pkg::wide_type'(s_ff) + (brc_pkg::wide_type'(se_ff) <<< 8), 8));
            t_in  = prod;
            mul_a = brc_pkg::mul_a_type'(-pos_sum_ff);
            mul_b = brc_pkg::KpPos;
         end
         brc_pkg::OP_DIFF: begin
            pos_in  = brc_pkg::sat16(brc_pkg::shr_trunc(prod, 8));
            diff_in = brc_pkg::mul_a_type'(
                         (brc_pkg::wide_type'(sm_ff) <<< 8) - brc_pkg::wide_type'(s_ff));
         end
         brc_pkg::OP_VE_A: begin
            mul_a = diff_ff;
            mul_b = brc_pkg::KVelNew;
         end
         brc_pkg::OP_VE_B: begin
            ve_in = brc_pkg::sat32(brc_pkg::shr_trunc(t_ff + prod, 8));
         end
         brc_pkg::OP_VEL_A: begin
            mul_a = brc_pkg::mul_a_type'(ve_ff);
            mul_b = brc_pkg::KpVel;
         end
         brc_pkg::OP_VEL_B: begin
            vel_in = brc_pkg::sat16(brc_pkg::shr_trunc(prod, 16));
         end
         brc_pkg::OP_DRIVE: begin
            kind_in     = 1'b0;
            drive_in    = brc_pkg::sat16(-brc_pkg::wide_type'(bal_ff)
                                         - brc_pkg::wide_type'(vel_ff)
                                         - brc_pkg::wide_type'(pos_ff));
            turn_out_in = turn_ff;
         end
         default: ;
      endcase
   end

   // Hold configuration and loop state; reset loads register defaults and clears loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_tilt_ff <= brc_pkg::MaxTiltReset;
         delay_ff    <= brc_pkg::RestandReset;
         scale_ff    <= brc_pkg::SpeedScaleReset;
         standup_ff  <= '0;
         pos_sum_ff  <= '0;
         se_ff       <= '0;
         ve_ff       <= '0;
      end else begin
         max_tilt_ff <= max_tilt_in;
         delay_ff    <= delay_in;
         scale_ff    <= scale_in;
         standup_ff  <= standup_in;
         pos_sum_ff  <= pos_sum_in;
         se_ff       <= se_in;
         ve_ff       <= ve_in;
      end
   end

   // Hold sample fields, intermediates and payload
   always_ff @(posedge clock) begin
      angle_ff    <= angle_in;
      gyro_ff     <= gyro_in;
      enc_ff      <= enc_in;
      now_ff      <= now_in;
      tgt_ff      <= tgt_in;
      turn_ff     <= turn_in;
      s_ff        <= s_in;
      t_ff        <= t_in;
      bal_ff      <= bal_in;
      err_ff      <= err_in;
      sm_ff       <= sm_in;
      pos_ff      <= pos_in;
      vel_ff      <= vel_in;
      diff_ff     <= diff_in;
      kind_ff     <= kind_in;
      drive_ff    <= drive_in;
      turn_out_ff <= turn_out_in;
   end

   assign rsp_kind  = kind_ff;
   assign rsp_drive = drive_ff;
   assign rsp_turn  = turn_out_ff;

endmodule

[design/brc_ctrl.sv]
// Controller of the balance cascade: request decimation, fall tracking,
// restand gating and sequencing of the datapath steps. Uses brc_pkg.
module brc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  brc_pkg::sts_type sts,
   output brc_pkg::cmd_type cmd
);

   typedef enum logic [16:0] {
      ST_IDLE  = 17'h00001,
      ST_CHECK = 17'h00002,
      ST_WAIT  = 17'h00004,
      ST_SHUT  = 17'h00008,
      ST_SPEED = 17'h00010,
      ST_BAL_A = 17'h00020,
      ST_BAL_B = 17'h00040,
      ST_ERR   = 17'h00080,
      ST_SE_A  = 17'h00100,
      ST_SE_B  = 17'h00200,
      ST_SM    = 17'h00400,
      ST_DIFF  = 17'h00800,
      ST_VE_A  = 17'h01000,
      ST_VE_B  = 17'h02000,
      ST_VEL_A = 17'h04000,
      ST_VEL_B = 17'h08000,
      ST_DRIVE = 17'h10000
   } state_type;

   state_type state_ff, state_in;
   logic      skip_ff, skip_in;
   logic      fallen_ff, fallen_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence one request through the steps
   always_comb begin
      state_in     = state_ff;
      skip_in      = skip_ff;
      fallen_in    = fallen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = brc_pkg::OP_NONE;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // Latch the sample; drop every other one
               cmd.op  = brc_pkg::OP_LOAD;
               skip_in = !skip_ff;
               if (skip_ff) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (sts.over_tilt) begin
               if (fallen_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  fallen_in = 1'b1;
                  state_in  = ST_SHUT;
               end
            end else begin
               if (fallen_ff) begin
                  fallen_in = 1'b0;
                  cmd.op    = brc_pkg::OP_STANDUP;
               end
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = sts.restand_wait ? ST_IDLE : ST_SPEED;
         end
         ST_SHUT: begin
            if (out_free) begin
               cmd.op       = brc_pkg::OP_CLEAR;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SPEED: begin
            cmd.op   = brc_pkg::OP_SPEED;
            state_in = ST_BAL_A;
         end
         ST_BAL_A: begin
            cmd.op   = brc_pkg::OP_BAL_A;
            state_in = ST_BAL_B;
         end
         ST_BAL_B: begin
            cmd.op   = brc_pkg::OP_BAL_B;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            cmd.op   = brc_pkg::OP_ERR;
            state_in = ST_SE_A;
         end
         ST_SE_A: begin
            cmd.op   = brc_pkg::OP_SE_A;
            state_in = ST_SE_B;
         end
         ST_SE_B: begin
            cmd.op   = brc_pkg::OP_SE_B;
            state_in = ST_SM;
         end
         ST_SM: begin
            cmd.op   = brc_pkg::OP_SM;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.op   = brc_pkg::OP_DIFF;
            state_in = ST_VE_A;
         end
         ST_VE_A: begin
            cmd.op   = brc_pkg::OP_VE_A;
            state_in = ST_VE_B;
         end
         ST_VE_B: begin
            cmd.op   = brc_pkg::OP_VE_B;
            state_in = ST_VEL_A;
         end
         ST_VEL_A: begin
            cmd.op   = brc_pkg::OP_VEL_A;
            state_in = ST_VEL_B;
         end
         ST_VEL_B: begin
            cmd.op   = brc_pkg::OP_VEL_B;
            state_in = ST_DRIVE;
         end
         ST_DRIVE: begin
            if (out_free) begin
               cmd.op       = brc_pkg::OP_DRIVE;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         skip_ff      <= 1'b0;
         fallen_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         skip_ff      <= skip_in;
         fallen_ff    <= fallen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[tb/balance_robot_cascade_controller_core_tb.sv]
// Self-checking testbench for the balance cascade controller core.
// Depends on brc_pkg, brc_req_if and brc_rsp_if; predicts every drive and shutdown
// command and checks the responses in order while both channels idle and stall.
module balance_robot_cascade_controller_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // One IMU sample as it travels on the request channel
   typedef struct {
      brc_pkg::angle_type tilt_angle;
      brc_pkg::word_type  gyro_rate;
      brc_pkg::word_type  encoder_delta;
      brc_pkg::ms_type    now_ms;
      brc_pkg::word_type  target_speed;
      brc_pkg::word_type  target_turn;
   } imu_sample_type;

   // One motor command as it comes back on the response channel
   typedef struct {
      logic              kind;
      brc_pkg::word_type drive;
      brc_pkg::word_type turn;
   } motor_cmd_type;

   localparam logic                   CmdDrive      = 1'b0;
   localparam logic                   CmdShutdown   = 1'b1;
   localparam brc_pkg::csr_index_type CsrUnused     = 2'd3;
   localparam int                     DrainCycles   = 40;
   localparam int                     WatchdogLimit = 2000;
   localparam int                     PhaseCount    = 8;
   localparam int                     PhaseRequests = 80;

   // Q8.8 gains and position limits of the cascade
   localparam longint GainBalP    = 115;
   localparam longint GainBalD    = 54;
   localparam longint SmoothKeep  = 179;
   localparam longint SmoothNew   = 77;
   localparam longint VelKeep     = 205;
   localparam longint VelNew      = 51;
   localparam longint GainVel     = 358;
   localparam longint GainPos     = 77;
   localparam longint PosLow      = -1000;
   localparam longint PosHigh     = 1000;
   localparam longint Int32Low    = -(longint'(1) << 31);
   localparam longint Int32High   = (longint'(1) << 31) - 1;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   brc_pkg::csr_index_type csr_index;
   brc_pkg::csr_data_type  csr_wdata;

   brc_req_if req_bus ();
   brc_rsp_if rsp_bus ();

   balance_robot_cascade_controller_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Register copies as the block should hold them
   logic [7:0]            tilt_limit = brc_pkg::MaxTiltReset;
   brc_pkg::csr_data_type restand_ms = brc_pkg::RestandReset;
   brc_pkg::csr_data_type speed_q88  = brc_pkg::SpeedScaleReset;

   // Controller state of the prediction
   bit                 skip_odd   = 1'b0;
   bit                 is_fallen  = 1'b0;
   brc_pkg::ms_type    standup_ms = '0;
   longint             pos_sum    = 0;
   longint             err_filt   = 0;
   longint             vel_err    = 0;

   imu_sample_type     imu_q[$];
   motor_cmd_type      motor_cmd_q[$];
   imu_sample_type     on_bus;
   motor_cmd_type      next_cmd;
   motor_cmd_type      want_cmd;
   brc_pkg::ms_type    clock_ms;
   int                 burst_left = 0;
   int                 gap_left   = 0;
   int                 stall_count = 0;
   logic [7:0]         ready_pat  = 8'hFF;
   int                 idle_cycles = 0;
   int                 mismatches = 0;

   function automatic longint clip(input longint x, input longint lo, input longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   function automatic longint clip16(input longint x);
      return clip(x, -32768, 32767);
   endfunction

   // Advance the controller by one sample; return 1 when a command comes out
   function automatic bit compute_motor_cmd(input imu_sample_type s, output motor_cmd_type c);
      longint angle, mag, enc, spd, bal, err, sm, vel, pos, drv;
      brc_pkg::ms_type since;
      c.kind  = CmdDrive;
      c.drive = '0;
      c.turn  = '0;
      skip_odd = ~skip_odd;
      if (skip_odd) return 1'b0;

      // fall test on the truncated whole degrees
      angle = longint'(s.tilt_angle);
      mag = (angle < 0 ? -angle : angle) >>> 8;
      if (mag > longint'(tilt_limit)) begin
         if (is_fallen) return 1'b0;
         is_fallen = 1'b1;
         pos_sum   = 0;
         err_filt  = 0;
         vel_err   = 0;
         c.kind    = CmdShutdown;
         return 1'b1;
      end
      if (is_fallen) begin
         is_fallen  = 1'b0;
         standup_ms = s.now_ms;
      end

      // hold off until the restand delay has run out
      since = s.now_ms - brc_pkg::ms_type'(restand_ms);
      if (since < standup_ms) return 1'b0;

      enc = longint'(s.encoder_delta);
      spd = enc * longint'(speed_q88);
      bal = clip16((GainBalP * angle + GainBalD * longint'(s.gyro_rate)) / 256);

      // velocity loop: smooth the error twice, then scale
      err = clip16((longint'(s.target_speed) * 256 - spd) / 256);
      err_filt = clip16((err_filt * SmoothKeep) / 256);
      err_filt = clip16((err_filt * 256 + SmoothNew * err) / 256);
      sm = clip16((spd + err_filt * 256) / 256);
      vel_err = clip((vel_err * VelKeep + (sm * 256 - spd) * VelNew) / 256, Int32Low, Int32High);
      vel = clip16((vel_err * GainVel) / 65536);

      // position loop on the clamped encoder sum
      pos_sum = clip(pos_sum + enc, PosLow, PosHigh);
      pos = clip16((-pos_sum * GainPos) / 256);

      drv = clip16(-bal - vel - pos);
      c.drive = brc_pkg::word_type'(drv);
      c.turn  = s.target_turn;
      return 1'b1;
   endfunction

   function automatic brc_pkg::word_type pick_word();
      case ($urandom_range(0, 7))
         0, 1: return brc_pkg::word_type'($urandom);
         2: return 16'sh7FFF;
         3: return 16'sh8000;
         4: return '0;
         default: return brc_pkg::word_type'(int'($urandom_range(0, 1000)) - 500);
      endcase
   endfunction

   // Angle that stays within the tilt limit, edges included
   function automatic brc_pkg::angle_type upright_angle();
      int lim;
      lim = int'(tilt_limit) * 256 + 255;
      if ($urandom_range(0, 7) == 0) begin
         return brc_pkg::angle_type'(($urandom_range(0, 1) != 0) ? lim : -lim);
      end
      return brc_pkg::angle_type'(int'($urandom_range(0, 2 * lim)) - lim);
   endfunction

   // Angle just or far beyond the tilt limit; the negative side reaches one step further
   function automatic brc_pkg::angle_type fallen_angle();
      int lo, mag;
      lo = (int'(tilt_limit) + 1) * 256;
      mag = ($urandom_range(0, 3) == 0) ? lo : int'($urandom_range(lo, 65536));
      if (mag > 65535 || $urandom_range(0, 1) == 0) return brc_pkg::angle_type'(-mag);
      return brc_pkg::angle_type'(mag);
   endfunction

   task automatic queue_sample(input brc_pkg::angle_type a, input brc_pkg::word_type g,
                               input brc_pkg::word_type e, input brc_pkg::ms_type t,
                               input brc_pkg::word_type ts, input brc_pkg::word_type tr);
      imu_sample_type s;
      s.tilt_angle    = a;
      s.gyro_rate     = g;
      s.encoder_delta = e;
      s.now_ms        = t;
      s.target_speed  = ts;
      s.target_turn   = tr;
      imu_q.push_back(s);
   endtask

   // Random sample in the dropped slot, then the sample that counts
   task automatic queue_pair(input brc_pkg::angle_type a, input brc_pkg::word_type g,
                             input brc_pkg::word_type e, input brc_pkg::ms_type t,
                             input brc_pkg::word_type ts, input brc_pkg::word_type tr);
      queue_sample(brc_pkg::angle_type'($urandom), pick_word(), pick_word(), $urandom,
                   pick_word(), pick_word());
      queue_sample(a, g, e, t, ts, tr);
   endtask

   task automatic write_reg(input brc_pkg::csr_index_type idx, input int unsigned val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= brc_pkg::csr_data_type'(val);
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         brc_pkg::CsrMaxTilt:    tilt_limit = val[7:0];
         brc_pkg::CsrRestand:    restand_ms = val[15:0];
         brc_pkg::CsrSpeedScale: speed_q88  = val[15:0];
         default: ;
      endcase
   endtask

   // Wait until every request is in and every command out, then let the block drain
   task automatic settle();
      while (imu_q.size() != 0 || req_bus.valid || motor_cmd_q.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Mostly upright runs with falls and recoveries in between, some noise and clock jumps
   task automatic build_phase(input int total);
      int made, pick, run;
      made = 0;
      while (made < total) begin
         pick = $urandom_range(0, 9);
         if (pick == 9) begin
            clock_ms = ($urandom_range(0, 1) != 0) ? brc_pkg::ms_type'($urandom) :
                       32'hFFFF_FFC0;
         end else begin
            run = (pick >= 6) ? $urandom_range(1, 6) : $urandom_range(4, 24);
            repeat (run) begin
               clock_ms += $urandom_range(0, 40);
               if (pick == 8) begin
                  queue_sample(brc_pkg::angle_type'($urandom), pick_word(), pick_word(),
                               $urandom, pick_word(), pick_word());
               end else begin
                  queue_sample((pick >= 6) ? fallen_angle() : upright_angle(), pick_word(),
                               pick_word(), clock_ms, pick_word(), pick_word());
               end
               made++;
            end
         end
      end
   endtask

   // Request driver: bursts of requests with random gaps, prediction on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (compute_motor_cmd(on_bus, next_cmd)) motor_cmd_q.push_back(next_cmd);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (imu_q.size() > 0) begin
               on_bus = imu_q.pop_front();
               req_bus.tilt_angle    <= on_bus.tilt_angle;
               req_bus.gyro_rate     <= on_bus.gyro_rate;
               req_bus.encoder_delta <= on_bus.encoder_delta;
               req_bus.now_ms        <= on_bus.now_ms;
               req_bus.target_speed  <= on_bus.target_speed;
               req_bus.target_turn   <= on_bus.target_turn;
               req_bus.valid         <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 :
                             $urandom_range(1, ($urandom_range(0, 7) == 0) ? 24 : 5);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response stall: rotate a ready pattern, reroll it now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (stall_count == 0) begin
            stall_count = $urandom_range(20, 80);
            ready_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
         end
         stall_count--;
         ready_pat = {ready_pat[0], ready_pat[7:1]};
         rsp_bus.ready <= ready_pat[0];
      end
   end

   // Response monitor: compare each command with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (motor_cmd_q.size() == 0) begin
            $display("%0t: unexpected command kind=%0d drive=%0d turn=%0d", $time,
                     rsp_bus.kind, rsp_bus.drive, rsp_bus.turn);
            mismatches++;
         end else begin
            want_cmd = motor_cmd_q.pop_front();
            if (rsp_bus.kind !== want_cmd.kind) begin
               $display("%0t: kind mismatch, expected %0d, got %0d", $time, want_cmd.kind,
                        rsp_bus.kind);
               mismatches++;
            end
            if (rsp_bus.drive !== want_cmd.drive) begin
               $display("%0t: drive mismatch, expected %0d, got %0d", $time, want_cmd.drive,
                        rsp_bus.drive);
               mismatches++;
            end
            if (rsp_bus.turn !== want_cmd.turn) begin
               $display("%0t: turn mismatch, expected %0d, got %0d", $time, want_cmd.turn,
                        rsp_bus.turn);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("balance_robot_cascade_controller_core_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned tilt, delay, scale;
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = brc_pkg::CsrMaxTilt;
      csr_wdata             = '0;
      req_bus.valid         = 1'b0;
      req_bus.tilt_angle    = '0;
      req_bus.gyro_rate     = '0;
      req_bus.encoder_delta = '0;
      req_bus.now_ms        = '0;
      req_bus.target_speed  = '0;
      req_bus.target_turn   = '0;
      rsp_bus.ready         = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, tilt edges, still fallen, restand wait and its end
      queue_pair('0, '0, '0, 32'd0, '0, '0);
      queue_pair(17'sd10495, 16'sh7FFF, 16'sh7FFF, 32'd10, 16'sh8000, 16'sh7FFF);
      queue_pair(-17'sd10495, 16'sh8000, 16'sh8000, 32'd20, 16'sh7FFF, 16'sh8000);
      queue_pair(17'sd10496, 16'sd5, 16'sd7, 32'd30, 16'sd9, 16'sd11);
      queue_pair(17'sd65535, 16'sd1, 16'sd1, 32'd40, 16'sd1, 16'sd1);
      queue_pair(17'sh10000, 16'sd2, 16'sd2, 32'd50, 16'sd2, 16'sd2);
      queue_pair('0, 16'sd100, 16'sd50, 32'd5000, 16'sd200, 16'sd300);
      queue_pair(17'sd256, 16'sd100, 16'sd50, 32'd5999, 16'sd200, 16'sd300);
      queue_pair(-17'sd2560, -16'sd300, 16'sd120, 32'd6000, -16'sd40, 16'sd77);
      queue_pair(-17'sd10496, 16'sd3, 16'sd3, 32'd6500, 16'sd3, 16'sd3);
      queue_pair(17'sd1000, 16'sd9, 16'sd9, 32'd7000, 16'sd9, 16'sd9);
      settle();

      // Random phases, each under its own register setting
      clock_ms = 32'd8000;
      for (int p = 0; p < PhaseCount; p++) begin
         case (p)
            0: begin
               tilt = 0;
               delay = 0;
               scale = 0;
            end
            1: begin
               tilt = 180;
               delay = 65535;
               scale = 65535;
            end
            2: begin
               tilt = 255;
               delay = $urandom_range(0, 100);
               scale = $urandom_range(0, 65535);
            end
            default: begin
               tilt = $urandom_range(0, 180);
               delay = $urandom_range(0, 300);
               scale = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 1024) :
                       $urandom_range(0, 65535);
            end
         endcase
         write_reg(brc_pkg::CsrMaxTilt, tilt);
         write_reg(brc_pkg::CsrRestand, delay);
         write_reg(brc_pkg::CsrSpeedScale, scale);
         if (p == 3) write_reg(CsrUnused, $urandom);
         build_phase(PhaseRequests);
         settle();
      end

      if (mismatches == 0 && motor_cmd_q.size() == 0) begin
         $display("balance_robot_cascade_controller_core_tb: done, clean");
      end else begin
         $display("balance_robot_cascade_controller_core_tb: done, errors");
      end
      $finish;
   end

endmodule
